[src/bitmap_set_clear_pop_core_defines.svh]
// assertion macros for the flag bitmap core
`ifndef BITMAP_SET_CLEAR_POP_CORE_DEFINES_SVH
`define BITMAP_SET_CLEAR_POP_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// property holds on every clock edge outside reset
`define BSCP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// consequent holds in the cycle after the antecedent
`define BSCP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define BSCP_ASSERT(lbl, prop, msg)
`define BSCP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[src/bscp_pkg.sv]
// types, codes and helpers of the flag bitmap core
`timescale 1ns / 1ps
package bscp_pkg;

  localparam int WORD_BITS = 32;
  localparam int BIT_W     = 5;
  localparam int IDX_W     = 10;
  localparam int LEN_W     = 11;
  localparam int CNT_W     = 11;
  localparam int NW_W      = 7;
  localparam int OP_W      = 2;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_POP   = 2'd1;
  localparam logic [OP_W-1:0] OP_INIT  = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_ALL_SET  = 1'd1;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef struct packed {
    logic              new_state;
    logic [IDX_W-1:0]  flag_index;
    logic [OP_W-1:0]   opcode;
  } in_beat_t;

  typedef struct packed {
    logic              bad_index;
    logic [CNT_W-1:0]  set_count;
    logic [IDX_W-1:0]  popped_index;
    logic              found;
    logic              old_state;
  } out_beat_t;

  // position of the lowest set bit, zero for an empty word
  function automatic logic [BIT_W-1:0] lowest_set(input word_t w);
    logic [BIT_W-1:0] b;
    b = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) b = BIT_W'(i);
    end
    return b;
  endfunction

endpackage

[src/bitmap_set_clear_pop_core.sv]
// flag bitmap core: write flag, pop a set flag (circular scan from the last popped word), reinitialize
`timescale 1ns / 1ps
`include "bitmap_set_clear_pop_core_defines.svh"
// path from input beat to result beat: write flag reads the word, then modifies it in S_WMOD;
//   bad index, empty pop or no-op go straight to S_RESP; pop reads one word per cycle from the flag
//   memory (up to nw words, nw = words in use); reinitialize: one word written per cycle by the fill walker
// one item in flight; the next beat is taken in the cycle after the result is handed over
// reset is synchronous and active low; after reset a clearing pass writes zero to all
//   NWORDS words of the flag memory, with in_tready low
module bitmap_set_clear_pop_core #(
  parameter int NBITS = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // opcode[1:0], flag_index[11:2], new_state[12], zero pad[15:13]
  input  logic [bscp_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // old_state[0], found[1], popped_index[11:2], set_count[22:12], bad_index[23]
  output logic [bscp_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                              cfg_we,
  input  logic [bscp_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [bscp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import bscp_pkg::*;

  localparam int NWORDS = (NBITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam logic [AW-1:0] LAST_WORD = AW'(NWORDS - 1);

  // control states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WMOD = 3'd1;  // read data of the written word is back
  localparam logic [2:0] S_POP  = 3'd2;  // circular word scan
  localparam logic [2:0] S_FILL = 3'd3;  // clear or fill walker
  localparam logic [2:0] S_RESP = 3'd4;  // result waits for the output register

  // flag memory, one word per entry, registered read
  word_t           mem [NWORDS];
  word_t           mem_q;
  logic            mem_we;
  logic [AW-1:0]   mem_wa;
  logic [AW-1:0]   mem_ra;
  word_t           mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_q <= mem[mem_ra];
  end

  // configuration registers
  logic [LEN_W-1:0] len_cfg_r;
  logic             init_all_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_cfg_r  <= LEN_W'(1024);
      init_all_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_VECTOR_LENGTH: len_cfg_r  <= cfg_wdata;
        REG_INIT_ALL_SET:  init_all_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // state and working registers
  logic [2:0]        state_r,     state_nxt;
  logic [CNT_W-1:0]  set_total_r, set_total_nxt;
  logic [AW-1:0]     search_r,    search_nxt;
  logic [AW-1:0]     word_r,      word_nxt;      // word of the flag being written
  logic [BIT_W-1:0]  bit_r,       bit_nxt;
  logic              nstate_r,    nstate_nxt;
  logic [AW-1:0]     fill_addr_r, fill_addr_nxt;
  logic              fill_set_r,  fill_set_nxt;
  logic              fill_resp_r, fill_resp_nxt; // walker ends with a result
  logic [AW-1:0]     scan_addr_r, scan_addr_nxt;
  logic [NW_W-1:0]   iss_left_r,  iss_left_nxt;  // words still to read
  logic [NW_W-1:0]   chk_left_r,  chk_left_nxt;  // words still to check
  logic [AW-1:0]     chk_addr_r,  chk_addr_nxt;
  logic              rd_vld_r,    rd_vld_nxt;
  out_beat_t         res_r,       res_nxt;
  logic              out_vld_r,   out_vld_nxt;
  out_beat_t         out_r,       out_nxt;

  // effective length and number of words in use
  logic [LEN_W-1:0]  len_eff;
  logic [NW_W-1:0]   nw;
  logic [AW-1:0]     start_word;
  logic [AW-1:0]     scan_next;
  in_beat_t          in_beat;
  logic              in_acc;
  logic              hit;
  logic [BIT_W-1:0]  hit_bit;
  logic [31:0]       fill_base;
  logic [31:0]       fill_gap;
  word_t             fill_word;
  logic              out_free;

  assign len_eff = (32'(len_cfg_r) > NBITS) ? LEN_W'(NBITS) : len_cfg_r;
  assign nw = NW_W'(({1'b0, len_eff} + (LEN_W + 1)'(WORD_BITS - 1)) >> BIT_W);
  // a stale pointer beyond the words in use restarts at word zero
  assign start_word = (32'(search_r) < 32'(nw)) ? search_r : '0;
  assign scan_next  = (32'(scan_addr_r) + 32'd1 == 32'(nw)) ? '0 : scan_addr_r + AW'(1);

  assign in_beat   = in_beat_t'(in_tdata[$bits(in_beat_t)-1:0]);
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  assign hit     = rd_vld_r && (mem_q != '0);
  assign hit_bit = lowest_set(mem_q);

  // fill pattern: flags below the length set when filling
  assign fill_base = 32'(fill_addr_r) << BIT_W;
  assign fill_gap  = (32'(len_eff) > fill_base) ? 32'(len_eff) - fill_base : 32'd0;
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      fill_word[i] = fill_set_r && (fill_gap > 32'(i));
    end
  end

  assign out_free = !out_vld_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    set_total_nxt = set_total_r;
    search_nxt    = search_r;
    word_nxt      = word_r;
    bit_nxt       = bit_r;
    nstate_nxt    = nstate_r;
    fill_addr_nxt = fill_addr_r;
    fill_set_nxt  = fill_set_r;
    fill_resp_nxt = fill_resp_r;
    scan_addr_nxt = scan_addr_r;
    iss_left_nxt  = iss_left_r;
    chk_left_nxt  = chk_left_r;
    chk_addr_nxt  = chk_addr_r;
    rd_vld_nxt    = 1'b0;
    res_nxt       = res_r;
    mem_we        = 1'b0;
    mem_wa        = '0;
    mem_wd        = '0;
    mem_ra        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_nxt   = '0;
          state_nxt = S_RESP;
          case (in_beat.opcode)
            OP_WRITE: begin
              if (11'(in_beat.flag_index) >= len_eff) begin
                res_nxt.bad_index = 1'b1;
              end else begin
                // read the word now, modify it when the data is back
                mem_ra     = AW'(in_beat.flag_index >> BIT_W);
                word_nxt   = AW'(in_beat.flag_index >> BIT_W);
                bit_nxt    = in_beat.flag_index[BIT_W-1:0];
                nstate_nxt = in_beat.new_state;
                state_nxt  = S_WMOD;
              end
            end
            OP_POP: begin
              if (set_total_r != '0 && nw != '0) begin
                scan_addr_nxt = start_word;
                iss_left_nxt  = nw;
                chk_left_nxt  = nw;
                state_nxt     = S_POP;
              end
            end
            OP_INIT: begin
              set_total_nxt = init_all_r ? len_eff : '0;
              search_nxt    = '0;
              fill_addr_nxt = '0;
              fill_set_nxt  = init_all_r;
              fill_resp_nxt = 1'b1;
              state_nxt     = S_FILL;
            end
            default: ;  // no-op reports the count only
          endcase
        end
      end

      S_WMOD: begin
        res_nxt.old_state = mem_q[bit_r];
        if (mem_q[bit_r] != nstate_r) begin
          mem_we = 1'b1;
          mem_wa = word_r;
          mem_wd = mem_q ^ (word_t'(1) << bit_r);
          if (nstate_r) begin
            if (32'(set_total_r) < NBITS) set_total_nxt = set_total_r + CNT_W'(1);
          end else if (set_total_r != '0) begin
            set_total_nxt = set_total_r - CNT_W'(1);
          end
        end
        state_nxt = S_RESP;
      end

      S_POP: begin
        // reads run one word ahead of the check
        if (iss_left_r != '0) begin
          mem_ra        = scan_addr_r;
          rd_vld_nxt    = 1'b1;
          chk_addr_nxt  = scan_addr_r;
          scan_addr_nxt = scan_next;
          iss_left_nxt  = iss_left_r - NW_W'(1);
        end
        if (rd_vld_r) begin
          chk_left_nxt = chk_left_r - NW_W'(1);
          if (hit) begin
            mem_we                = 1'b1;
            mem_wa                = chk_addr_r;
            mem_wd                = mem_q & ~(word_t'(1) << hit_bit);
            set_total_nxt         = set_total_r - CNT_W'(1);
            search_nxt            = chk_addr_r;
            res_nxt.found         = 1'b1;
            res_nxt.popped_index  = IDX_W'({chk_addr_r, hit_bit});
            rd_vld_nxt            = 1'b0;
            state_nxt             = S_RESP;
          end else if (chk_left_r == NW_W'(1)) begin
            // count says set but no set flag in the words in use
            rd_vld_nxt = 1'b0;
            state_nxt  = S_RESP;
          end
        end
      end

      S_FILL: begin
        mem_we = 1'b1;
        mem_wa = fill_addr_r;
        mem_wd = fill_word;
        if (fill_addr_r == LAST_WORD) begin
          state_nxt = fill_resp_r ? S_RESP : S_IDLE;
        end else begin
          fill_addr_nxt = fill_addr_r + AW'(1);
        end
      end

      S_RESP: begin
        if (out_free) state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // output register
  always_comb begin
    out_vld_nxt = out_vld_r;
    out_nxt     = out_r;
    if (state_r == S_RESP && out_free) begin
      out_vld_nxt       = 1'b1;
      out_nxt           = res_r;
      out_nxt.set_count = set_total_r;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;  // clearing pass
      set_total_r <= '0;
      search_r    <= '0;
      fill_addr_r <= '0;
      fill_set_r  <= 1'b0;
      fill_resp_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      set_total_r <= set_total_nxt;
      search_r    <= search_nxt;
      fill_addr_r <= fill_addr_nxt;
      fill_set_r  <= fill_set_nxt;
      fill_resp_r <= fill_resp_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r      <= word_nxt;
    bit_r       <= bit_nxt;
    nstate_r    <= nstate_nxt;
    scan_addr_r <= scan_addr_nxt;
    iss_left_r  <= iss_left_nxt;
    chk_left_r  <= chk_left_nxt;
    chk_addr_r  <= chk_addr_nxt;
    res_r       <= res_nxt;
    out_r       <= out_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_TDATA_W'(out_r);

  `BSCP_ASSERT(a_count_bound, (32'(set_total_r) <= NBITS), "set count above capacity")
  `BSCP_ASSERT(a_mem_we_state, (!mem_we || state_r == S_WMOD || state_r == S_POP || state_r == S_FILL), "flag memory written outside a modify state")
  `BSCP_ASSERT_NEXT(a_pop_dec, (state_r == S_POP && hit), (set_total_r == $past(set_total_r) - CNT_W'(1)), "pop hit without count decrement")
  `BSCP_ASSERT_NEXT(a_resp_hold, (state_r == S_RESP && out_vld_r && !out_tready), (state_r == S_RESP), "result dropped while output stalled")

endmodule
